FILE: src/mdu_pkg.sv
// ----------------------------------------------------------------------------
// mdu_pkg
// Shared types, operation codes and the divide step for the RV32M unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package mdu_pkg;

	localparam int unsigned XLEN = 32;
	localparam int unsigned RIDX = 5;
	localparam int unsigned DIV_STAGES = XLEN;

	typedef enum logic [2:0] {
		OP_MUL    = 3'd0,
		OP_MULH   = 3'd1,
		OP_MULHSU = 3'd2,
		OP_MULHU  = 3'd3,
		OP_DIV    = 3'd4,
		OP_DIVU   = 3'd5,
		OP_REM    = 3'd6,
		OP_REMU   = 3'd7
	} mdu_op_t;

	typedef struct packed {
		logic [2:0]      operation;
		logic [XLEN-1:0] operand_a;
		logic [XLEN-1:0] operand_b;
		logic [RIDX-1:0] dest_index;
	} mdu_cmd_t;

	typedef struct packed {
		logic [XLEN-1:0] result_value;
		logic [RIDX-1:0] result_dest;
	} mdu_rsp_t;

	// Work carried down the pipeline
	typedef struct packed {
		mdu_op_t           op;
		logic [RIDX-1:0]   dest;
		logic              neg;
		logic              bzero;
		logic [XLEN-1:0]   rem;
		logic [XLEN-1:0]   quo;
		logic [XLEN-1:0]   dvs;
		logic [47:0]       pp_lo;
		logic [47:0]       pp_hi;
		logic [2*XLEN-1:0] prod;
	} mdu_work_t;

	typedef struct packed {
		logic [XLEN-1:0] rem;
		logic [XLEN-1:0] quo;
	} mdu_div_t;

	// One restoring divide step: shift in the next dividend bit, try the subtract
	function automatic mdu_div_t div_step(input logic [XLEN-1:0] rem,
		input logic [XLEN-1:0] quo, input logic [XLEN-1:0] dvs);
		logic [XLEN:0]   t;
		logic [XLEN+1:0] diff;
		logic            ge;
		mdu_div_t        r;
		t    = {rem, quo[XLEN-1]};
		diff = {1'b0, t} - {2'b00, dvs};
		ge   = ~diff[XLEN+1];
		r.rem = ge ? diff[XLEN-1:0] : t[XLEN-1:0];
		r.quo = {quo[XLEN-2:0], ge};
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: src/mdu_prep.sv
// ----------------------------------------------------------------------------
// mdu_prep
// Entry stage: decode the operation, take operand magnitudes and note signs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mdu_prep (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	output logic                   cmd_stall,
	input  wire mdu_pkg::mdu_cmd_t cmd,
	output logic                   work_valid,
	input  wire logic              work_stall,
	output mdu_pkg::mdu_work_t     work
);

	mdu_pkg::mdu_op_t   op;
	logic               sa, sb, na, nb;
	logic [31:0]        x, y;
	mdu_pkg::mdu_work_t nxt;
	logic               v_s1;
	mdu_pkg::mdu_work_t w_s1;

	// Decode signedness and result sign
	always_comb begin
		op = mdu_pkg::mdu_op_t'(cmd.operation);
		sa = (op == mdu_pkg::OP_MULH) || (op == mdu_pkg::OP_MULHSU) ||
			(op == mdu_pkg::OP_DIV) || (op == mdu_pkg::OP_REM);
		sb = (op == mdu_pkg::OP_MULH) || (op == mdu_pkg::OP_DIV) ||
			(op == mdu_pkg::OP_REM);
		na = sa & cmd.operand_a[31];
		nb = sb & cmd.operand_b[31];
		x  = na ? (32'd0 - cmd.operand_a) : cmd.operand_a;
		y  = nb ? (32'd0 - cmd.operand_b) : cmd.operand_b;
		nxt       = '0;
		nxt.op    = op;
		nxt.dest  = cmd.dest_index;
		nxt.bzero = (cmd.operand_b == 32'd0);
		nxt.quo   = x;
		nxt.dvs   = y;
		case (op)
			mdu_pkg::OP_MULH, mdu_pkg::OP_DIV: nxt.neg = na ^ nb;
			mdu_pkg::OP_MULHSU, mdu_pkg::OP_REM: nxt.neg = na;
			default: nxt.neg = 1'b0;
		endcase
	end

	assign cmd_stall = v_s1 & work_stall;

	// Hold while the next stage is blocked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			v_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd_stall && cmd_valid) begin
			w_s1 <= nxt;
		end
	end

	assign work_valid = v_s1;
	assign work       = w_s1;

endmodule
`default_nettype wire

FILE: src/mdu_core.sv
// ----------------------------------------------------------------------------
// mdu_core
// Thirty-two stage divide pipeline; the first two stages also form the product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mdu_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire mdu_pkg::mdu_work_t in_work,
	output logic                    done_valid,
	input  wire logic               done_stall,
	output mdu_pkg::mdu_work_t      done_work
);

	localparam int unsigned N = mdu_pkg::DIV_STAGES;

	logic               v_s [N];
	mdu_pkg::mdu_work_t w_s [N];
	logic               blk [N+1];

	assign blk[N] = done_stall;

	genvar i;
	generate
		for (i = 0; i < N; i++) begin : g_stage
			logic               vin;
			mdu_pkg::mdu_work_t win;
			mdu_pkg::mdu_work_t nxt;
			mdu_pkg::mdu_div_t  d;

			if (i == 0) begin : g_first
				assign vin = in_valid;
				assign win = in_work;
			end else begin : g_rest
				assign vin = v_s[i-1];
				assign win = w_s[i-1];
			end

			assign blk[i] = v_s[i] & blk[i+1];

			// Divide step, plus the partial products and their sum up front
			always_comb begin
				d       = mdu_pkg::div_step(win.rem, win.quo, win.dvs);
				nxt     = win;
				nxt.rem = d.rem;
				nxt.quo = d.quo;
				if (i == 0) begin
					nxt.pp_lo = 48'(win.quo) * 48'(win.dvs[15:0]);
					nxt.pp_hi = 48'(win.quo) * 48'(win.dvs[31:16]);
				end
				if (i == 1) begin
					nxt.prod = {16'd0, win.pp_lo} + {win.pp_hi, 16'd0};
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[i] <= 1'b0;
				end else if (!blk[i]) begin
					v_s[i] <= vin;
				end
			end

			always_ff @(posedge clk) begin
				if (!blk[i] && vin) begin
					w_s[i] <= nxt;
				end
			end
		end
	endgenerate

	assign in_stall   = blk[0];
	assign done_valid = v_s[N-1];
	assign done_work  = w_s[N-1];

endmodule
`default_nettype wire

FILE: src/mdu_fin.sv
// ----------------------------------------------------------------------------
// mdu_fin
// Final stage: apply result signs, pick the result and register it out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mdu_fin (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               work_valid,
	output logic                    work_stall,
	input  wire mdu_pkg::mdu_work_t work,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output mdu_pkg::mdu_rsp_t       rsp
);

	logic [63:0]       pv;
	logic [31:0]       res;
	logic              rsp_valid_q;
	mdu_pkg::mdu_rsp_t rsp_q;

	// Select the result for the operation
	always_comb begin
		pv = work.neg ? (64'd0 - work.prod) : work.prod;
		case (work.op)
			mdu_pkg::OP_MUL: res = work.prod[31:0];
			mdu_pkg::OP_MULH, mdu_pkg::OP_MULHSU, mdu_pkg::OP_MULHU: res = pv[63:32];
			mdu_pkg::OP_DIV, mdu_pkg::OP_DIVU:
				res = work.bzero ? 32'hFFFF_FFFF :
					(work.neg ? (32'd0 - work.quo) : work.quo);
			default: res = work.neg ? (32'd0 - work.rem) : work.rem;
		endcase
	end

	assign work_stall = rsp_valid_q & rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (!work_stall) begin
			rsp_valid_q <= work_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!work_stall && work_valid) begin
			rsp_q.result_value <= res;
			rsp_q.result_dest  <= work.dest;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

FILE: src/multiply_divide_unit_32.sv
// ----------------------------------------------------------------------------
// multiply_divide_unit_32
// RV32M multiply and divide unit, fully pipelined.
// ----------------------------------------------------------------------------
// One command enters per cycle while the input is not stalled and passes through one
// entry stage, 32 divide stages (one restoring quotient bit each, with the
// 32x16 partial products and their sum in the first two) and one output
// stage. Every stage holds when the one after it is full and blocked, so
// commands are taken while a result waits, and a stalled command stays put.
`timescale 1ns / 1ps
`default_nettype none
module multiply_divide_unit_32 (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	output logic                   cmd_stall,
	input  wire mdu_pkg::mdu_cmd_t cmd,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output mdu_pkg::mdu_rsp_t      rsp
);

	logic               prep_valid, prep_stall;
	mdu_pkg::mdu_work_t prep_work;
	logic               core_valid, core_stall;
	mdu_pkg::mdu_work_t core_work;

	mdu_prep u_prep (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.work_valid(prep_valid), .work_stall(prep_stall), .work(prep_work)
	);

	mdu_core u_core (
		.clk(clk), .arst_n(arst_n),
		.in_valid(prep_valid), .in_stall(prep_stall), .in_work(prep_work),
		.done_valid(core_valid), .done_stall(core_stall), .done_work(core_work)
	);

	mdu_fin u_fin (
		.clk(clk), .arst_n(arst_n),
		.work_valid(core_valid), .work_stall(core_stall), .work(core_work),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

endmodule
`default_nettype wire

FILE: src/mdu_checker.sv
// ----------------------------------------------------------------------------
// mdu_checker
// Port-level checks on the multiply and divide unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mdu_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              cmd_valid,
	input wire logic              cmd_stall,
	input wire mdu_pkg::mdu_cmd_t cmd,
	input wire logic              rsp_valid,
	input wire logic              rsp_stall,
	input wire mdu_pkg::mdu_rsp_t rsp
);

	// No beat leaves during reset
	a_rst_quiet: assert property (@(posedge clk) !arst_n |-> !rsp_valid)
		else $error("result beat during reset");

	// Input backs up only when the output is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> (rsp_valid && rsp_stall))
		else $error("command stalled without blocked result");

	// Blocked result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
		else $error("stalled result beat changed");

	// Blocked command beat holds
	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_stall) |=> (cmd_valid && $stable(cmd)))
		else $error("stalled command beat changed");

	// Nothing comes out of an empty pipe as reset is released
	a_first_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !rsp_valid)
		else $error("result beat straight after reset");

endmodule

bind multiply_divide_unit_32 mdu_checker u_mdu_checker (
	.clk(clk), .arst_n(arst_n),
	.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
	.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
);
`default_nettype wire
